// File: hw/rtl/ssp_pkg.sv
// Shared types, register indexes and reset constants for the stepper seek
// position controller. No dependencies.
package ssp_pkg;

  localparam int unsigned POS_W = 11;
  localparam int unsigned PER_W = 8;
  localparam int unsigned TGT_W = 16;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CFG_W = 11;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_TRAVEL_LIMIT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_NEAR_DISTANCE = 3'd1;
  localparam logic [IDX_W-1:0] REG_NEAR_PERIOD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FAR_PERIOD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEADBAND      = 3'd4;
  localparam logic [IDX_W-1:0] REG_SETTLE_TICKS  = 3'd5;

  localparam logic [POS_W-1:0] TRAVEL_LIMIT_RST  = 11'd1600;
  localparam logic [POS_W-1:0] NEAR_DISTANCE_RST = 11'd50;
  localparam logic [PER_W-1:0] NEAR_PERIOD_RST   = 8'd10;
  localparam logic [PER_W-1:0] FAR_PERIOD_RST    = 8'd5;
  localparam logic [PER_W-1:0] DEADBAND_RST      = 8'd5;
  localparam logic [PER_W-1:0] SETTLE_TICKS_RST  = 8'd5;
  localparam logic [PER_W-1:0] PERIOD_RST        = 8'd10;

  // Item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SEEK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MOVE   = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] travel_limit;
    logic [POS_W-1:0] near_distance;
    logic [PER_W-1:0] near_period;
    logic [PER_W-1:0] far_period;
    logic [PER_W-1:0] deadband;
    logic [PER_W-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                    func;
    logic signed [TGT_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic             step_pulse;
    logic             direction;
    logic             driver_off;
    logic [POS_W-1:0] position;
    logic             seek_accepted;
  } result_t;

endpackage

// File: hw/rtl/ssp_cfg_regs.sv
// Configuration register file of the stepper seek position controller.
// Depends on ssp_pkg.
module ssp_cfg_regs
  import ssp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.travel_limit  <= TRAVEL_LIMIT_RST;
      cfg.near_distance <= NEAR_DISTANCE_RST;
      cfg.near_period   <= NEAR_PERIOD_RST;
      cfg.far_period    <= FAR_PERIOD_RST;
      cfg.deadband      <= DEADBAND_RST;
      cfg.settle_ticks  <= SETTLE_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRAVEL_LIMIT:  cfg.travel_limit  <= cfg_data[POS_W-1:0];
        REG_NEAR_DISTANCE: cfg.near_distance <= cfg_data[POS_W-1:0];
        REG_NEAR_PERIOD:   cfg.near_period   <= cfg_data[PER_W-1:0];
        REG_FAR_PERIOD:    cfg.far_period    <= cfg_data[PER_W-1:0];
        REG_DEADBAND:      cfg.deadband      <= cfg_data[PER_W-1:0];
        REG_SETTLE_TICKS:  cfg.settle_ticks  <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/ssp_in_stage.sv
// Input register of the stepper seek position controller: holds one beat
// until the motion stage takes it. Depends on ssp_pkg.
module ssp_in_stage
  import ssp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// File: hw/rtl/ssp_motion.sv
// Motion state of the stepper seek position controller: position, goal,
// period, phase, tick counter and direction, updated once per item.
// Depends on ssp_pkg.
module ssp_motion
  import ssp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] goal, goal_next;
  logic [PER_W-1:0] period, period_next;
  phase_t           phase, phase_next;
  logic [PER_W-1:0] tick_counter, tick_counter_next;
  logic             dir, dir_next;

  logic             above;
  logic             at_goal;
  logic [POS_W-1:0] pos_gap;
  logic [POS_W-1:0] step_pos;
  logic [PER_W-1:0] step_tc;
  logic             in_range;
  logic [POS_W-1:0] raw_pos;
  logic [POS_W-1:0] seek_pos;
  logic [POS_W-1:0] seek_dist;
  logic             idle_check;
  logic             do_step;
  logic             pulse;
  logic             accepted;

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      goal         <= '0;
      period       <= PERIOD_RST;
      phase        <= PH_IDLE;
      tick_counter <= '0;
      dir          <= 1'b0;
    end else if (advance) begin
      position     <= position_next;
      goal         <= goal_next;
      period       <= period_next;
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      dir          <= dir_next;
    end
  end

  assign above    = position > goal;
  assign at_goal  = position == goal;
  assign pos_gap  = above ? position - goal : goal - position;
  assign step_pos = above ? position - 1'b1 : position + 1'b1;
  assign step_tc  = (period > 8'd1) ? period - 1'b1 : '0;

  // Seek: negative targets and targets at or past the travel limit are dropped
  assign in_range  = !item.target[TGT_W-1] &&
                     (item.target[TGT_W-2:0] < {{(TGT_W-1-POS_W){1'b0}}, cfg.travel_limit});
  assign raw_pos   = item.target[POS_W-1:0];
  assign seek_pos  = (position == '0) ? raw_pos : position;
  assign seek_dist = (seek_pos > raw_pos) ? seek_pos - raw_pos : raw_pos - seek_pos;

  always_comb begin
    position_next     = position;
    goal_next         = goal;
    period_next       = period;
    phase_next        = phase;
    tick_counter_next = tick_counter;
    dir_next          = dir;
    idle_check        = 1'b0;
    do_step           = 1'b0;
    pulse             = 1'b0;
    accepted          = 1'b0;

    if (item.func == FUNC_SEEK) begin
      if (in_range) begin
        accepted      = 1'b1;
        position_next = seek_pos;
        goal_next     = raw_pos;
        period_next   = (seek_dist < cfg.near_distance) ? cfg.near_period : cfg.far_period;
      end
    end else begin
      unique case (phase)
        PH_MOVE: begin
          if (tick_counter != '0) tick_counter_next = tick_counter - 1'b1;
          else                    do_step = 1'b1;
        end
        PH_SETTLE: begin
          if (tick_counter != '0) tick_counter_next = tick_counter - 1'b1;
          else                    idle_check = 1'b1;
        end
        default: idle_check = 1'b1;
      endcase

      if (idle_check) begin
        phase_next = PH_IDLE;
        if (pos_gap >= {{(POS_W-PER_W){1'b0}}, cfg.deadband}) begin
          do_step = 1'b1;
        end
      end

      if (do_step) begin
        if (at_goal) begin
          phase_next        = PH_SETTLE;
          tick_counter_next = cfg.settle_ticks;
        end else begin
          phase_next        = PH_MOVE;
          position_next     = step_pos;
          dir_next          = !above;
          tick_counter_next = step_tc;
          pulse             = 1'b1;
        end
      end
    end
  end

  assign res.step_pulse    = pulse;
  assign res.direction     = dir_next;
  assign res.driver_off    = phase_next != PH_MOVE;
  assign res.position      = position_next;
  assign res.seek_accepted = accepted;

endmodule

// File: hw/rtl/ssp_out_stage.sv
// Result register of the stepper seek position controller: holds a finished
// beat until the receiver takes it. Depends on ssp_pkg.
module ssp_out_stage
  import ssp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: hw/rtl/stepper_seek_position_controller_core.sv
// Stepper seek position controller, top level.
// Instantiates ssp_cfg_regs, ssp_in_stage, ssp_motion and ssp_out_stage; uses ssp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, func, target) carries one item per
//   beat: func = 0 is a one-millisecond tick, func = 1 a seek to target.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   item: step_pulse, direction, driver_off, position, seek_accepted.
//   Configuration must be written through cfg_wr_en/cfg_index/cfg_data while the
//   block is idle, which the block does not enforce; a write takes effect at once.
// Timing:
//   An accepted item sits in the input register, is processed by the motion
//   logic and lands in the result register once that register is free or
//   draining. One item per cycle is sustained while out_ready stays high;
//   the motion state update is a single combinational pass.
// Reset (rst, synchronous): both pipeline registers empty, position and
//   goal zero, period 10, phase idle, configuration at its reset values.
// Stall: while the receiver holds out_ready low, the result stays put and
//   one more item is still taken into the input register; then in_ready
//   drops until the result is taken.
module stepper_seek_position_controller_core
  import ssp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic signed [TGT_W-1:0] target,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    step_pulse,
  output logic                    direction,
  output logic                    driver_off,
  output logic [POS_W-1:0]        position,
  output logic                    seek_accepted,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t res_next;
  result_t res_q;

  assign in_item.func   = func;
  assign in_item.target = target;

  // Advance when a held beat exists and the result register is free or draining
  assign advance = held_valid && (!out_valid || out_ready);

  ssp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ssp_motion u_motion (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .res     (res_next)
  );

  ssp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign step_pulse    = res_q.step_pulse;
  assign direction     = res_q.direction;
  assign driver_off    = res_q.driver_off;
  assign position      = res_q.position;
  assign seek_accepted = res_q.seek_accepted;

endmodule

// File: hw/rtl/ssp_checker.sv
// Port-level checks for the stepper seek position controller, bound to the
// top level. Depends on ssp_pkg.
module ssp_checker
  import ssp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             step_pulse,
  input logic             driver_off,
  input logic [POS_W-1:0] position,
  input logic             seek_accepted
);

  // A stalled result beat holds its position
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(step_pulse))
    else $error("result beat changed while stalled");

  // A seek never makes a step
  a_seek_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && seek_accepted |-> !step_pulse)
    else $error("step pulse on a seek beat");

  // A step only happens with the driver enabled
  a_step_driver_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_pulse |-> !driver_off)
    else $error("step pulse with driver disabled");

  // Nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stepper_seek_position_controller_core ssp_checker u_ssp_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for stepper_seek_position_controller_core.
// Drives tick and seek beats, predicts every result beat and checks it.
// Depends on ssp_pkg and the core RTL only.
`timescale 1ns / 100ps

import ssp_pkg::*;

class stepper_scoreboard;
  cfg_t                    cfg;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        goal;
  logic [PER_W-1:0]        period;
  logic [PER_W-1:0]        count;
  phase_t                  ph;
  logic                    dir_up;
  result_t                 pending[$];
  int unsigned             failures;

  function new();
    cfg.travel_limit  = TRAVEL_LIMIT_RST;
    cfg.near_distance = NEAR_DISTANCE_RST;
    cfg.near_period   = NEAR_PERIOD_RST;
    cfg.far_period    = FAR_PERIOD_RST;
    cfg.deadband      = DEADBAND_RST;
    cfg.settle_ticks  = SETTLE_TICKS_RST;
    pos      = '0;
    goal     = '0;
    period   = PERIOD_RST;
    count    = '0;
    ph       = PH_IDLE;
    dir_up   = 1'b0;
    failures = 0;
  endfunction

  function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_TRAVEL_LIMIT:  cfg.travel_limit  = value;
      REG_NEAR_DISTANCE: cfg.near_distance = value;
      REG_NEAR_PERIOD:   cfg.near_period   = value[PER_W-1:0];
      REG_FAR_PERIOD:    cfg.far_period    = value[PER_W-1:0];
      REG_DEADBAND:      cfg.deadband      = value[PER_W-1:0];
      REG_SETTLE_TICKS:  cfg.settle_ticks  = value[PER_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [POS_W-1:0] gap();
    return (pos > goal) ? pos - goal : goal - pos;
  endfunction

  // Take one step toward the goal, or finish the move when there.
  function logic step_or_land();
    if (pos == goal) begin
      ph    = PH_SETTLE;
      count = cfg.settle_ticks;
      return 1'b0;
    end
    if (pos > goal) begin
      dir_up = 1'b0;
      pos    = pos - 1'b1;
    end else begin
      dir_up = 1'b1;
      pos    = pos + 1'b1;
    end
    count = (period > 8'd1) ? period - 8'd1 : 8'd0;
    return 1'b1;
  endfunction

  function logic tick_motion();
    if (ph == PH_MOVE) begin
      if (count != 0) begin
        count = count - 1'b1;
        return 1'b0;
      end
      return step_or_land();
    end
    if (ph == PH_SETTLE && count != 0) begin
      count = count - 1'b1;
      return 1'b0;
    end
    // settling done (or idle): poll on this same tick
    ph = PH_IDLE;
    if (gap() >= cfg.deadband) begin
      ph = PH_MOVE;
      return step_or_land();
    end
    return 1'b0;
  endfunction

  function void note_item(logic f, logic signed [TGT_W-1:0] t);
    result_t r;
    r = '0;
    if (f == FUNC_TICK) begin
      r.step_pulse = tick_motion();
    end else if (!t[TGT_W-1] && t[TGT_W-2:0] < cfg.travel_limit) begin
      r.seek_accepted = 1'b1;
      if (pos == 0)
        pos = t[POS_W-1:0];
      goal   = t[POS_W-1:0];
      period = (gap() < cfg.near_distance) ? cfg.near_period : cfg.far_period;
    end
    r.direction  = dir_up;
    r.driver_off = (ph != PH_MOVE);
    r.position   = pos;
    pending.push_back(r);
  endfunction

  function void report(string field, int unsigned want, int unsigned seen);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    failures++;
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (pending.size() == 0) begin
      $display("%0t: result beat with none expected, actual %h", $time, got);
      failures++;
      return;
    end
    want = pending.pop_front();
    if (got.step_pulse !== want.step_pulse)
      report("step_pulse", want.step_pulse, got.step_pulse);
    if (got.direction !== want.direction)
      report("direction", want.direction, got.direction);
    if (got.driver_off !== want.driver_off)
      report("driver_off", want.driver_off, got.driver_off);
    if (got.position !== want.position)
      report("position", want.position, got.position);
    if (got.seek_accepted !== want.seek_accepted)
      report("seek_accepted", want.seek_accepted, got.seek_accepted);
  endfunction
endclass

module testbench;
  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    func;
  logic signed [TGT_W-1:0] target;
  logic                    out_valid;
  logic                    out_ready;
  logic                    step_pulse;
  logic                    direction;
  logic                    driver_off;
  logic [POS_W-1:0]        position;
  logic                    seek_accepted;
  logic                    cfg_wr_en;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  stepper_scoreboard sb;
  int unsigned       idle_odds;

  stepper_seek_position_controller_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(func, target);
      if (out_valid && out_ready)
        sb.check_result(result_t'({step_pulse, direction, driver_off, position,
                                   seek_accepted}));
    end
  end

  // Receiver: stall in random bursts.
  initial begin
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        hold = $urandom_range(1, 8);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic f, logic signed [TGT_W-1:0] t);
    int unsigned pause;
    pause = 0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
      pause = $urandom_range(1, 8);
    if (pause != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (pause - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    target   <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item();
    int unsigned roll;
    int unsigned span;
    int          pick;
    roll = $urandom_range(0, 99);
    if (roll < 78) begin
      send_item(FUNC_TICK, 16'($urandom_range(0, 65535)));
    end else if (roll < 93) begin
      // well-formed seek close to where the motor is
      span = ($urandom_range(0, 4) == 0) ? 400 : 40;
      pick = int'(sb.pos) + int'($urandom_range(0, 2 * span)) - int'(span);
      if ($urandom_range(0, 19) == 0)
        pick = 0;
      if (pick < 0)
        pick = 0;
      if (pick >= int'(sb.cfg.travel_limit))
        pick = int'(sb.cfg.travel_limit) - 1;
      send_item(FUNC_SEEK, 16'(pick));
    end else begin
      send_item(FUNC_SEEK, 16'($urandom_range(0, 65535)));
    end
  endtask

  // Drop valid and wait until every result beat has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_setup(cfg_t c);
    write_reg(REG_TRAVEL_LIMIT, c.travel_limit);
    write_reg(REG_NEAR_DISTANCE, c.near_distance);
    write_reg(REG_NEAR_PERIOD, CFG_W'(c.near_period));
    write_reg(REG_FAR_PERIOD, CFG_W'(c.far_period));
    write_reg(REG_DEADBAND, CFG_W'(c.deadband));
    write_reg(REG_SETTLE_TICKS, CFG_W'(c.settle_ticks));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    cfg_t setup;
    sb        = new();
    idle_odds = 4;
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = FUNC_TICK;
    target    = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: rejects at both ends, jump from zero, deadband, retarget mid-move.
    send_item(FUNC_TICK, 16'hFFFF);
    send_item(FUNC_SEEK, 16'sd0);
    send_item(FUNC_SEEK, -16'sd1);
    send_item(FUNC_SEEK, 16'sh8000);
    send_item(FUNC_SEEK, 16'sh7FFF);
    send_item(FUNC_SEEK, 16'sd1600);
    send_item(FUNC_SEEK, 16'sd1599);
    send_item(FUNC_SEEK, 16'sd1596);
    send_item(FUNC_TICK, 16'h0000);
    send_item(FUNC_TICK, 16'h5555);
    send_item(FUNC_SEEK, 16'sd1580);
    repeat (4) send_item(FUNC_TICK, 16'hAAAA);
    send_item(FUNC_SEEK, 16'sd1400);
    repeat (6) send_item(FUNC_TICK, 16'h8001);
    send_item(FUNC_SEEK, 16'sd2047);
    drain();

    for (int ph_i = 1; ph_i <= 8; ph_i++) begin
      case (ph_i)
        1: setup = '{11'd2047, 11'd0, 8'd2, 8'd2, 8'd1, 8'd0};
        2: setup = '{11'd1, 11'd2047, 8'd255, 8'd255, 8'd255, 8'd255};
        3: setup = '{11'd1600, 11'd2047, 8'd2, 8'd255, 8'd1, 8'd255};
        default: setup = '{11'($urandom_range(64, 2047)), 11'($urandom_range(0, 200)),
                           8'($urandom_range(2, 6)), 8'($urandom_range(2, 4)),
                           8'($urandom_range(1, 8)), 8'($urandom_range(0, 10))};
      endcase
      apply_setup(setup);
      // no idling in the last phase
      if (ph_i == 8)
        idle_odds = 0;
      else
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 8;
        endcase
      repeat (166) random_item();
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
